### rtl/apm_pkg.sv
package apm_pkg;

    localparam int CW   = 32;
    localparam int DW   = 33;
    localparam int PW   = 66;
    localparam int DETW = 67;
    localparam int NW   = 102;
    localparam int QB   = 33;
    localparam int NL   = 6;

    typedef struct packed {
        logic signed [CW-1:0] src_x0;
        logic signed [CW-1:0] src_y0;
        logic signed [CW-1:0] src_x1;
        logic signed [CW-1:0] src_y1;
        logic signed [CW-1:0] src_x2;
        logic signed [CW-1:0] src_y2;
        logic signed [CW-1:0] dst_x0;
        logic signed [CW-1:0] dst_y0;
        logic signed [CW-1:0] dst_x1;
        logic signed [CW-1:0] dst_y1;
        logic signed [CW-1:0] dst_x2;
        logic signed [CW-1:0] dst_y2;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] scale_x;
        logic signed [CW-1:0] shear_y;
        logic signed [CW-1:0] shear_x;
        logic signed [CW-1:0] scale_y;
        logic signed [CW-1:0] offset_x;
        logic signed [CW-1:0] offset_y;
        logic                 singular;
    } t_out;

endpackage

### rtl/affine_parallelogram_mapping_unit.sv
// Maps three source corners and three destination corners (signed Q16.16 by
// default, FRAC_BITS fraction bits) to the six coefficients of the affine
// transform between them, rounded to nearest with ties away from zero and
// saturated to 32 bits; a zero source determinant gives singular = 1 and zero
// coefficients. The unit is fully pipelined: one item may enter every cycle
// while the result is not stalled. Eight stages form the differences, products,
// determinant, numerators and their magnitudes; a 33-stage restoring divider
// (one quotient bit per stage, six lanes) and one rounding and saturation stage
// follow. A stalled result holds the whole pipeline.
module affine_parallelogram_mapping_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  apm_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output apm_pkg::t_out  o_data
);
    import apm_pkg::*;

    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    // stage 1: corner differences
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_d, r1_da, r1_db, r1_dc, r1_dd;
    logic signed [CW-1:0] r1_sx0, r1_sy0, r1_dx0, r1_dy0;
    // stage 2: products
    logic signed [PW-1:0] r2_ad, r2_bc, r2_dda, r2_bdc, r2_ddb, r2_bdd;
    logic signed [PW-1:0] r2_adc, r2_cda, r2_add, r2_cdb;
    logic signed [PW-2:0] r2_syc, r2_sxd, r2_sxb, r2_sya;
    logic signed [DW-1:0] r2_da, r2_db, r2_dc, r2_dd;
    logic signed [CW-1:0] r2_dx0, r2_dy0;
    // stage 3: determinant and differences of products
    logic signed [DETW-1:0] r3_det, r3_m0, r3_m1, r3_m2, r3_m3;
    logic signed [PW-1:0]   r3_tx, r3_ty;
    logic signed [DW-1:0]   r3_da, r3_db, r3_dc, r3_dd;
    logic signed [CW-1:0]   r3_dx0, r3_dy0;
    // stage 4: partial products of the offset numerators
    logic signed [DETW-1:0] r4_txl_da, r4_txl_db, r4_tyl_dc, r4_tyl_dd;
    logic signed [PW-1:0]   r4_txh_da, r4_txh_db, r4_tyh_dc, r4_tyh_dd;
    logic signed [DETW-1:0] r4_dx0_dl, r4_dy0_dl;
    logic signed [PW-2:0]   r4_dx0_dh, r4_dy0_dh;
    logic signed [DETW-1:0] r4_det, r4_m0, r4_m1, r4_m2, r4_m3;
    // stage 5: combined partial products
    logic signed [NW-1:0]   r5_ex0, r5_ex1, r5_ex2, r5_ey0, r5_ey1, r5_ey2;
    logic signed [DETW-1:0] r5_det, r5_m0, r5_m1, r5_m2, r5_m3;
    // stage 6: numerators
    logic signed [NW-1:0]   r6_n [NL];
    logic signed [DETW-1:0] r6_det;
    // stage 7: magnitudes
    logic [NW-1:0]   r7_u [NL];
    logic [NL-1:0]   r7_neg;
    logic [DETW-1:0] r7_den;
    logic            r7_sg;

    // divider pipeline, index 0 is stage 8
    logic [NL-1:0][DETW+QB-1:0] r_rq  [0:QB];
    logic [DETW-1:0]            r_den [0:QB];
    logic [NL-1:0]              r_neg [0:QB];
    logic [NL-1:0]              r_ovf [0:QB];
    logic                       r_sg  [0:QB];
    logic                       r_dv  [0:QB];

    function automatic logic [DETW+QB-1:0] div_step(input logic [DETW+QB-1:0] rq,
                                                     input logic [DETW-1:0] den);
        logic [DETW+QB:0] sh;
        logic [DETW:0]    top;
        logic [DETW+1:0]  dif;
        sh  = {rq, 1'b0};
        top = sh[DETW+QB:QB];
        dif = {1'b0, top} - {2'b00, den};
        if (!dif[DETW+1]) begin
            div_step = {dif[DETW-1:0], sh[QB-1:1], 1'b1};
        end else begin
            div_step = {top[DETW-1:0], sh[QB-1:0]};
        end
    endfunction

    function automatic logic [CW-1:0] round_sat(input logic [DETW+QB-1:0] rq,
                                                 input logic [DETW-1:0] den,
                                                 input logic neg, input logic ovf);
        logic [DETW:0]  rem2;
        logic [QB:0]    qr;
        logic [CW-1:0]  lo;
        rem2 = {rq[DETW+QB-1:QB], 1'b0};
        qr   = {1'b0, rq[QB-1:0]} + (QB+1)'(rem2 >= {1'b0, den});
        lo   = qr[CW-1:0];
        if (!neg) begin
            round_sat = (ovf || qr > (QB+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : lo;
        end else begin
            round_sat = (ovf || qr > (QB+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : -lo;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_a   <= DW'(i_data.src_x1) - DW'(i_data.src_x0);
            r1_b   <= DW'(i_data.src_y1) - DW'(i_data.src_y0);
            r1_c   <= DW'(i_data.src_x2) - DW'(i_data.src_x0);
            r1_d   <= DW'(i_data.src_y2) - DW'(i_data.src_y0);
            r1_da  <= DW'(i_data.dst_x1) - DW'(i_data.dst_x0);
            r1_db  <= DW'(i_data.dst_y1) - DW'(i_data.dst_y0);
            r1_dc  <= DW'(i_data.dst_x2) - DW'(i_data.dst_x0);
            r1_dd  <= DW'(i_data.dst_y2) - DW'(i_data.dst_y0);
            r1_sx0 <= i_data.src_x0;
            r1_sy0 <= i_data.src_y0;
            r1_dx0 <= i_data.dst_x0;
            r1_dy0 <= i_data.dst_y0;

            r2_ad  <= r1_a * r1_d;
            r2_bc  <= r1_b * r1_c;
            r2_dda <= r1_d * r1_da;
            r2_bdc <= r1_b * r1_dc;
            r2_ddb <= r1_d * r1_db;
            r2_bdd <= r1_b * r1_dd;
            r2_adc <= r1_a * r1_dc;
            r2_cda <= r1_c * r1_da;
            r2_add <= r1_a * r1_dd;
            r2_cdb <= r1_c * r1_db;
            r2_syc <= r1_sy0 * r1_c;
            r2_sxd <= r1_sx0 * r1_d;
            r2_sxb <= r1_sx0 * r1_b;
            r2_sya <= r1_sy0 * r1_a;
            r2_da  <= r1_da;
            r2_db  <= r1_db;
            r2_dc  <= r1_dc;
            r2_dd  <= r1_dd;
            r2_dx0 <= r1_dx0;
            r2_dy0 <= r1_dy0;

            r3_det <= DETW'(r2_ad) - DETW'(r2_bc);
            r3_m0  <= DETW'(r2_dda) - DETW'(r2_bdc);
            r3_m1  <= DETW'(r2_ddb) - DETW'(r2_bdd);
            r3_m2  <= DETW'(r2_adc) - DETW'(r2_cda);
            r3_m3  <= DETW'(r2_add) - DETW'(r2_cdb);
            r3_tx  <= PW'(r2_syc) - PW'(r2_sxd);
            r3_ty  <= PW'(r2_sxb) - PW'(r2_sya);
            r3_da  <= r2_da;
            r3_db  <= r2_db;
            r3_dc  <= r2_dc;
            r3_dd  <= r2_dd;
            r3_dx0 <= r2_dx0;
            r3_dy0 <= r2_dy0;

            // low halves unsigned, high halves signed
            r4_txl_da <= $signed({1'b0, r3_tx[DW-1:0]}) * r3_da;
            r4_txl_db <= $signed({1'b0, r3_tx[DW-1:0]}) * r3_db;
            r4_tyl_dc <= $signed({1'b0, r3_ty[DW-1:0]}) * r3_dc;
            r4_tyl_dd <= $signed({1'b0, r3_ty[DW-1:0]}) * r3_dd;
            r4_txh_da <= $signed(r3_tx[PW-1:DW]) * r3_da;
            r4_txh_db <= $signed(r3_tx[PW-1:DW]) * r3_db;
            r4_tyh_dc <= $signed(r3_ty[PW-1:DW]) * r3_dc;
            r4_tyh_dd <= $signed(r3_ty[PW-1:DW]) * r3_dd;
            r4_dx0_dl <= r3_dx0 * $signed({1'b0, r3_det[DW:0]});
            r4_dy0_dl <= r3_dy0 * $signed({1'b0, r3_det[DW:0]});
            r4_dx0_dh <= r3_dx0 * $signed(r3_det[DETW-1:DW+1]);
            r4_dy0_dh <= r3_dy0 * $signed(r3_det[DETW-1:DW+1]);
            r4_det    <= r3_det;
            r4_m0     <= r3_m0;
            r4_m1     <= r3_m1;
            r4_m2     <= r3_m2;
            r4_m3     <= r3_m3;

            r5_ex0 <= (NW'(r4_txh_da) <<< DW) + NW'(r4_txl_da);
            r5_ex1 <= (NW'(r4_tyh_dc) <<< DW) + NW'(r4_tyl_dc);
            r5_ex2 <= (NW'(r4_dx0_dh) <<< (DW+1)) + NW'(r4_dx0_dl);
            r5_ey0 <= (NW'(r4_txh_db) <<< DW) + NW'(r4_txl_db);
            r5_ey1 <= (NW'(r4_tyh_dd) <<< DW) + NW'(r4_tyl_dd);
            r5_ey2 <= (NW'(r4_dy0_dh) <<< (DW+1)) + NW'(r4_dy0_dl);
            r5_det <= r4_det;
            r5_m0  <= r4_m0;
            r5_m1  <= r4_m1;
            r5_m2  <= r4_m2;
            r5_m3  <= r4_m3;

            r6_n[0] <= NW'(r5_m0) <<< FRAC_BITS;
            r6_n[1] <= NW'(r5_m1) <<< FRAC_BITS;
            r6_n[2] <= NW'(r5_m2) <<< FRAC_BITS;
            r6_n[3] <= NW'(r5_m3) <<< FRAC_BITS;
            r6_n[4] <= r5_ex0 + r5_ex1 + r5_ex2;
            r6_n[5] <= r5_ey0 + r5_ey1 + r5_ey2;
            r6_det  <= r5_det;

            for (int i = 0; i < NL; i++) begin
                r7_u[i]   <= r6_n[i][NW-1] ? NW'(-r6_n[i]) : NW'(r6_n[i]);
                r7_neg[i] <= r6_n[i][NW-1] ^ r6_det[DETW-1];
            end
            r7_den <= r6_det[DETW-1] ? DETW'(-r6_det) : DETW'(r6_det);
            r7_sg  <= (r6_det == '0);

            for (int i = 0; i < NL; i++) begin
                r_rq[0][i]  <= r7_u[i][DETW+QB-1:0];
                r_ovf[0][i] <= r7_u[i] >= NW'({r7_den, QB'(0)});
            end
            r_den[0] <= r7_den;
            r_neg[0] <= r7_neg;
            r_sg[0]  <= r7_sg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_v7;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int i = 0; i < NL; i++) begin
                    r_rq[k+1][i] <= div_step(r_rq[k][i], r_den[k]);
                end
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_sg[k+1]  <= r_sg[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    t_out n_out, r_out;
    logic r_ov;
    logic [CW-1:0] n_c [NL];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            n_c[i] = r_sg[QB] ? '0 :
                     round_sat(r_rq[QB][i], r_den[QB], r_neg[QB][i], r_ovf[QB][i]);
        end
        n_out.scale_x  = n_c[0];
        n_out.shear_y  = n_c[1];
        n_out.shear_x  = n_c[2];
        n_out.scale_y  = n_c[3];
        n_out.offset_x = n_c[4];
        n_out.offset_y = n_c[5];
        n_out.singular = r_sg[QB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |-> (o_data.scale_x == 0 && o_data.shear_y == 0 &&
            o_data.shear_x == 0 && o_data.scale_y == 0 &&
            o_data.offset_x == 0 && o_data.offset_y == 0))
        else $error("singular item with nonzero coefficients");

    a_backpress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("pipeline not held under output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_dv[QB]) && $stable(r_v7)))
        else $error("pipeline moved while stalled");

endmodule
